// ----- hw/rtl/ucb_pkg.sv -----
package ucb_pkg;

  // result word kinds
  localparam logic [1:0] KIND_SERIAL = 2'd0;
  localparam logic [1:0] KIND_SPI    = 2'd1;
  localparam logic [1:0] KIND_DUMMY  = 2'd2;
  localparam logic [1:0] KIND_PINS   = 2'd3;

  // command bytes
  localparam logic [7:0] CMD_CFG_RESET = 8'h10;
  localparam logic [7:0] CMD_STREAM    = 8'h11;
  localparam logic [7:0] CMD_DUMMY_CLK = 8'h13;
  localparam logic [7:0] CMD_END_PROG  = 8'h14;
  localparam logic [7:0] CMD_DONE_POLL = 8'h15;
  localparam logic [7:0] CMD_XFER      = 8'h16;
  localparam logic [7:0] CMD_SELECT    = 8'h17;
  localparam logic [7:0] CMD_ECHO      = 8'h42;
  localparam logic [7:0] CMD_LOOPBACK  = 8'h55;

  // reply and pattern bytes
  localparam logic [7:0] REPLY_ERROR   = 8'hfe;
  localparam logic [7:0] REPLY_DONE    = 8'hd0;
  localparam logic [7:0] REPLY_BUSY    = 8'hbd;
  localparam logic [7:0] REPLY_END     = 8'h22;
  localparam logic [7:0] REPLY_UNKNOWN = 8'h80;
  localparam logic [7:0] LOOP_PREFIX   = 8'h11;
  localparam logic [7:0] LOOP_PATTERN  = 8'haa;

  localparam int MAX_RESULTS = 4;
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       select_level;
    logic       reset_level;
    logic       indicator_level;
  } result_t;

  // all result words caused by one input word
  typedef struct packed {
    logic [RES_IDX_W-1:0]          last_idx;
    result_t [MAX_RESULTS-1:0]     res;
  } bundle_t;

endpackage

// ----- hw/rtl/ucb_front.sv -----
module ucb_front
  import ucb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [7:0] byte_value,
  input  logic       rx_error,
  input  logic       done_level,
  input  logic       q_full,
  output logic       push,
  output bundle_t    push_bundle
);

  localparam logic [2:0] PH_CMD    = 3'd0;
  localparam logic [2:0] PH_ARG    = 3'd1;
  localparam logic [2:0] PH_STREAM = 3'd2;
  localparam logic [2:0] PH_XFER   = 3'd3;
  localparam logic [2:0] PH_LOOP_A = 3'd4;
  localparam logic [2:0] PH_LOOP_B = 3'd5;
  localparam logic [2:0] PH_LOOP_C = 3'd6;

  logic [2:0] phase, phase_next;
  logic [7:0] command_code, command_code_next;
  logic [7:0] argument, argument_next;
  logic [7:0] remaining, remaining_next;
  logic       status_good, status_good_next;
  logic       select_pin, select_pin_next;
  logic       reset_pin, reset_pin_next;
  logic       indicator_pin, indicator_pin_next;

  logic       accept;
  logic       has_res;
  logic       good_arg;
  logic       mismatch_ind;
  logic [7:0] done_reply;
  logic [7:0] rem_dec;
  bundle_t    bundle;

  function automatic result_t mk(input logic [1:0] k, input logic [7:0] b,
                                 input logic s, input logic r, input logic i);
    result_t x;
    x.kind            = k;
    x.out_byte        = b;
    x.select_level    = s;
    x.reset_level     = r;
    x.indicator_level = i;
    return x;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_next         = phase;
    command_code_next  = command_code;
    argument_next      = argument;
    remaining_next     = remaining;
    status_good_next   = status_good;
    select_pin_next    = select_pin;
    reset_pin_next     = reset_pin;
    indicator_pin_next = indicator_pin;
    bundle             = '0;
    has_res            = 1'b0;
    good_arg           = status_good && !rx_error;
    mismatch_ind       = indicator_pin || (byte_value != argument);
    done_reply         = done_level ? REPLY_DONE : REPLY_BUSY;
    rem_dec            = remaining - 8'd1;

    if (!action) begin
      unique case (phase)
        PH_CMD: begin
          command_code_next = byte_value;
          status_good_next  = !rx_error;
          phase_next        = PH_ARG;
        end
        PH_ARG: begin
          argument_next    = byte_value;
          status_good_next = good_arg;
          phase_next       = PH_CMD;
          has_res          = 1'b1;
          if (!good_arg) begin
            bundle.res[0]   = mk(KIND_SERIAL, REPLY_ERROR, select_pin, reset_pin,
                                 indicator_pin);
            bundle.res[1]   = mk(KIND_SERIAL, command_code, select_pin, reset_pin,
                                 indicator_pin);
            bundle.last_idx = RES_IDX_W'(1);
          end else begin
            bundle.res[0] = mk(KIND_SERIAL, command_code, select_pin, reset_pin,
                               indicator_pin);
            unique case (command_code)
              CMD_CFG_RESET: begin
                bundle.res[1]   = mk(KIND_PINS, 8'h00, 1'b0, 1'b0, indicator_pin);
                bundle.res[2]   = mk(KIND_PINS, 8'h00, 1'b0, 1'b1, indicator_pin);
                bundle.res[3]   = mk(KIND_SERIAL, done_reply, 1'b0, 1'b1,
                                     indicator_pin);
                bundle.last_idx = RES_IDX_W'(3);
                select_pin_next = 1'b0;
                reset_pin_next  = 1'b1;
              end
              CMD_STREAM: begin
                remaining_next = byte_value;
                if (byte_value == 8'h00) begin
                  bundle.res[1]   = mk(KIND_SERIAL, byte_value, select_pin, reset_pin,
                                       indicator_pin);
                  bundle.last_idx = RES_IDX_W'(1);
                end else begin
                  bundle.last_idx = RES_IDX_W'(0);
                  phase_next      = PH_STREAM;
                end
              end
              CMD_DUMMY_CLK: begin
                bundle.res[1]   = mk(KIND_DUMMY, byte_value, select_pin, reset_pin,
                                     indicator_pin);
                bundle.res[2]   = mk(KIND_SERIAL, byte_value, select_pin, reset_pin,
                                     indicator_pin);
                bundle.last_idx = RES_IDX_W'(2);
              end
              CMD_END_PROG: begin
                bundle.res[1]   = mk(KIND_PINS, 8'h00, 1'b1, 1'b1, indicator_pin);
                bundle.res[2]   = mk(KIND_SERIAL, REPLY_END, 1'b1, 1'b1, indicator_pin);
                bundle.last_idx = RES_IDX_W'(2);
                select_pin_next = 1'b1;
                reset_pin_next  = 1'b1;
              end
              CMD_DONE_POLL: begin
                bundle.res[1]   = mk(KIND_SERIAL, done_reply, select_pin, reset_pin,
                                     indicator_pin);
                bundle.last_idx = RES_IDX_W'(1);
              end
              CMD_XFER: begin
                bundle.res[1]   = mk(KIND_SPI, byte_value, select_pin, reset_pin,
                                     indicator_pin);
                bundle.last_idx = RES_IDX_W'(1);
                phase_next      = PH_XFER;
              end
              CMD_SELECT: begin
                bundle.res[1]   = mk(KIND_PINS, 8'h00, byte_value[0], reset_pin,
                                     indicator_pin);
                bundle.res[2]   = mk(KIND_SERIAL, {7'd0, byte_value[0]}, byte_value[0],
                                     reset_pin, indicator_pin);
                bundle.last_idx = RES_IDX_W'(2);
                select_pin_next = byte_value[0];
              end
              CMD_ECHO: begin
                bundle.res[1]   = mk(KIND_SERIAL, byte_value, select_pin, reset_pin,
                                     indicator_pin);
                bundle.last_idx = RES_IDX_W'(1);
              end
              CMD_LOOPBACK: begin
                bundle.res[1]      = mk(KIND_PINS, 8'h00, 1'b1, reset_pin, 1'b0);
                bundle.res[2]      = mk(KIND_PINS, 8'h00, 1'b0, reset_pin, 1'b0);
                bundle.res[3]      = mk(KIND_SPI, LOOP_PREFIX, 1'b0, reset_pin, 1'b0);
                bundle.last_idx    = RES_IDX_W'(3);
                indicator_pin_next = 1'b0;
                select_pin_next    = 1'b0;
                phase_next         = PH_LOOP_A;
              end
              default: begin
                // unknown command: flagged echo of the code, then the argument
                bundle.res[0]   = mk(KIND_SERIAL, command_code | REPLY_UNKNOWN,
                                     select_pin, reset_pin, indicator_pin);
                bundle.res[1]   = mk(KIND_SERIAL, byte_value, select_pin, reset_pin,
                                     indicator_pin);
                bundle.last_idx = RES_IDX_W'(1);
              end
            endcase
          end
        end
        PH_STREAM: begin
          has_res       = 1'b1;
          bundle.res[0] = mk(KIND_SPI, byte_value, select_pin, reset_pin,
                             indicator_pin);
          if (rx_error) begin
            status_good_next = 1'b0;
            bundle.res[1]    = mk(KIND_SERIAL, ~argument, select_pin, reset_pin,
                                  indicator_pin);
            bundle.last_idx  = RES_IDX_W'(1);
            phase_next       = PH_CMD;
          end else begin
            remaining_next = rem_dec;
            if (rem_dec == 8'h00) begin
              bundle.res[1]   = mk(KIND_SERIAL, argument, select_pin, reset_pin,
                                   indicator_pin);
              bundle.last_idx = RES_IDX_W'(1);
              phase_next      = PH_CMD;
            end else begin
              bundle.last_idx = RES_IDX_W'(0);
            end
          end
        end
        PH_XFER, PH_LOOP_A, PH_LOOP_B, PH_LOOP_C: begin
          // serial word dropped while an SPI reply is pending
        end
        default: phase_next = PH_CMD;
      endcase
    end else begin
      unique case (phase)
        PH_XFER: begin
          has_res         = 1'b1;
          bundle.res[0]   = mk(KIND_SERIAL, byte_value, select_pin, reset_pin,
                               indicator_pin);
          bundle.last_idx = RES_IDX_W'(0);
          phase_next      = PH_CMD;
        end
        PH_LOOP_A: begin
          has_res         = 1'b1;
          bundle.res[0]   = mk(KIND_SPI, argument, select_pin, reset_pin,
                               indicator_pin);
          bundle.last_idx = RES_IDX_W'(0);
          phase_next      = PH_LOOP_B;
        end
        PH_LOOP_B: begin
          has_res         = 1'b1;
          bundle.res[0]   = mk(KIND_SPI, LOOP_PATTERN, select_pin, reset_pin,
                               indicator_pin);
          bundle.last_idx = RES_IDX_W'(0);
          phase_next      = PH_LOOP_C;
        end
        PH_LOOP_C: begin
          has_res            = 1'b1;
          bundle.res[0]      = mk(KIND_PINS, 8'h00, select_pin, reset_pin,
                                  mismatch_ind);
          bundle.res[1]      = mk(KIND_SERIAL, byte_value, select_pin, reset_pin,
                                  mismatch_ind);
          bundle.res[2]      = mk(KIND_PINS, 8'h00, 1'b1, reset_pin, mismatch_ind);
          bundle.last_idx    = RES_IDX_W'(2);
          indicator_pin_next = mismatch_ind;
          select_pin_next    = 1'b1;
          phase_next         = PH_CMD;
        end
        PH_CMD, PH_ARG, PH_STREAM: begin
          // stray SPI reply
        end
        default: phase_next = PH_CMD;
      endcase
    end
  end

  assign push        = accept && has_res;
  assign push_bundle = bundle;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_CMD;
      command_code  <= 8'h00;
      argument      <= 8'h00;
      remaining     <= 8'h00;
      status_good   <= 1'b1;
      select_pin    <= 1'b1;
      reset_pin     <= 1'b1;
      indicator_pin <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      command_code  <= command_code_next;
      argument      <= argument_next;
      remaining     <= remaining_next;
      status_good   <= status_good_next;
      select_pin    <= select_pin_next;
      reset_pin     <= reset_pin_next;
      indicator_pin <= indicator_pin_next;
    end
  end

`ifndef ASSERT_OFF
  a_stream_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_STREAM |-> remaining != 8'h00)
    else $error("stream phase with zero count");

  a_loop_select: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LOOP_A || phase == PH_LOOP_B || phase == PH_LOOP_C) |-> !select_pin)
    else $error("select released during loopback");
`endif

endmodule

// ----- hw/rtl/ucb_queue.sv -----
module ucb_queue
  import ucb_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_bundle,
  input  logic    pop,
  output bundle_t head,
  output logic    empty,
  output logic    full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t            mem [DEPTH];
  logic [PTR_W-1:0]   wptr, rptr;
  logic [CNT_W-1:0]   count;

  function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= inc(wptr);
      end
      if (pop) begin
        rptr <= inc(rptr);
      end
      priority if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");
`endif

endmodule

// ----- hw/rtl/ucb_back.sv -----
module ucb_back
  import ucb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  bundle_t    head,
  input  logic       head_valid,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] out_byte,
  output logic       select_level,
  output logic       reset_level,
  output logic       indicator_level,
  output logic       last
);

  logic [RES_IDX_W-1:0] idx;
  logic                 load;
  logic                 take_last;
  result_t              out_res;
  logic                 out_last;

  // output register is free when empty or being taken this cycle
  assign load      = head_valid && (!out_valid || out_ready);
  assign take_last = (idx == head.last_idx);
  assign pop       = load && take_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= take_last ? '0 : idx + RES_IDX_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res  <= head.res[idx];
      out_last <= take_last;
    end
  end

  assign kind            = out_res.kind;
  assign out_byte        = out_res.out_byte;
  assign select_level    = out_res.select_level;
  assign reset_level     = out_res.reset_level;
  assign indicator_level = out_res.indicator_level;
  assign last            = out_last;

`ifndef ASSERT_OFF
  a_burst_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside a result burst");
`endif

endmodule

// ----- hw/rtl/uart_to_spi_config_bridge.sv -----
// Serial-to-SPI configuration command bridge. Received serial words (action 0,
// with rx_error) and SPI reply words (action 1) come in on one valid/ready
// channel; two-byte commands (command, argument) turn into result words on
// the output channel: serial transmit, SPI byte, dummy clock burst or pin
// update, each carrying the select/reset/indicator levels that hold after it,
// with last set on the final word caused by an input word. A front parser
// classifies each input word as it is accepted and queues all of its result
// words (up to four) as one entry; the back end plays them out one word per
// cycle while out_ready is high, through an output register. Input is taken
// every cycle while the queue (QUEUE_DEPTH entries) has room; sustained
// throughput is set by the back end at one output word per cycle, so an input
// word costs as many output words as it has result words, and words that
// cause no result add no queue entry. The first result word passes through
// the queue and then the output register before it is valid.
module uart_to_spi_config_bridge
  import ucb_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2   // bundle queue entries, 2 or more
) (
  input  logic       clk,
  input  logic       rst,
  // input words
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [7:0] byte_value,
  input  logic       rx_error,
  input  logic       done_level,
  // result words
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] out_byte,
  output logic       select_level,
  output logic       reset_level,
  output logic       indicator_level,
  output logic       last
);

  logic    q_full;
  logic    q_empty;
  logic    push;
  logic    pop;
  bundle_t push_bundle;
  bundle_t head;

  // parser: command state, pin state, builds result bundles
  ucb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .byte_value  (byte_value),
    .rx_error    (rx_error),
    .done_level  (done_level),
    .q_full      (q_full),
    .push        (push),
    .push_bundle (push_bundle)
  );

  // decouples parser from output backpressure
  ucb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_bundle (push_bundle),
    .pop         (pop),
    .head        (head),
    .empty       (q_empty),
    .full        (q_full)
  );

  // serializes one bundle into result words
  ucb_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .head_valid      (!q_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .out_byte        (out_byte),
    .select_level    (select_level),
    .reset_level     (reset_level),
    .indicator_level (indicator_level),
    .last            (last)
  );

endmodule

// ----- test/tb.sv -----
// Self-checking bench for the serial-to-SPI command bridge.
//
// Input words (serial bytes and SPI replies) are queued up front by an
// initial block and played into the block by a clocked driver that sends in
// bursts of random length with random gaps. A clocked monitor checks every
// result word against a queue of expected words. A behavioral model of the
// command parser fills that queue as each input word is accepted. The
// receiver stalls on a rotating ready pattern that is reloaded now and then.
module tb;
  import ucb_pkg::*;

  // action codes of an input word
  localparam logic SERIAL_WORD = 1'b0;
  localparam logic SPI_WORD    = 1'b1;

  localparam int TARGET_WORDS = 420;
  localparam int HOLD_EVERY   = 150;   // random words between full drains
  localparam int TAIL_CYCLES  = 16;    // settle time after the last result

  // parser phases of the bridge
  typedef enum logic [3:0] {
    WAIT_CMD,
    WAIT_ARG,
    STREAMING,
    XFER_WAIT,
    LOOP_FIRST,
    LOOP_SECOND,
    LOOP_THIRD
  } bridge_phase_e;

  // one input word; a hold entry is not sent, it makes the driver pause
  // until every expected result word has come back
  typedef struct {
    logic       act;
    logic [7:0] value;
    logic       err;
    logic       done;
    bit         hold;
  } host_word_t;

  typedef struct packed {
    result_t res;
    logic    last;
  } reply_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       action = 1'b0;
  logic [7:0] byte_value = 8'h00;
  logic       rx_error = 1'b0;
  logic       done_level = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       select_level;
  logic       reset_level;
  logic       indicator_level;
  logic       last;

  uart_to_spi_config_bridge dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .byte_value     (byte_value),
    .rx_error       (rx_error),
    .done_level     (done_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .out_byte       (out_byte),
    .select_level   (select_level),
    .reset_level    (reset_level),
    .indicator_level(indicator_level),
    .last           (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  host_word_t  host_words[$];       // words still to be sent
  reply_word_t pending_replies[$];  // result words still owed by the block

  int stim_count      = 0;
  int words_accepted  = 0;
  int cmds_dispatched = 0;
  int results_checked = 0;
  int mismatches      = 0;

  // ---------------------------------------------------------------------
  // Command parser model: its own copy of the bridge state
  // ---------------------------------------------------------------------
  bridge_phase_e phase       = WAIT_CMD;
  logic [7:0]    cur_cmd     = 8'h00;
  logic [7:0]    cur_arg     = 8'h00;
  logic [7:0]    stream_left = 8'h00;
  logic          status_ok   = 1'b1;
  logic          sel_pin     = 1'b1;
  logic          rst_pin     = 1'b1;
  logic          ind_pin     = 1'b0;

  function automatic bit is_bridge_cmd(input logic [7:0] code);
    case (code)
      CMD_CFG_RESET, CMD_STREAM, CMD_DUMMY_CLK, CMD_END_PROG, CMD_DONE_POLL,
      CMD_XFER, CMD_SELECT, CMD_ECHO, CMD_LOOPBACK: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // every word carries the pin levels as they stand once it takes effect
  task automatic push_reply(input logic [1:0] k, input logic [7:0] v);
    reply_word_t w;
    w.res.kind            = k;
    w.res.out_byte        = v;
    w.res.select_level    = sel_pin;
    w.res.reset_level     = rst_pin;
    w.res.indicator_level = ind_pin;
    w.last                = 1'b0;
    pending_replies.push_back(w);
  endtask

  // full command (command byte + argument) received with good status
  task automatic run_command(input logic dn);
    phase = WAIT_CMD;
    cmds_dispatched++;
    if (!is_bridge_cmd(cur_cmd)) begin
      push_reply(KIND_SERIAL, cur_cmd | REPLY_UNKNOWN);
      push_reply(KIND_SERIAL, cur_arg);
      return;
    end
    push_reply(KIND_SERIAL, cur_cmd);
    case (cur_cmd)
      CMD_CFG_RESET: begin
        sel_pin = 1'b0;
        rst_pin = 1'b0;
        push_reply(KIND_PINS, 8'h00);
        rst_pin = 1'b1;
        push_reply(KIND_PINS, 8'h00);
        push_reply(KIND_SERIAL, dn ? REPLY_DONE : REPLY_BUSY);
      end
      CMD_STREAM: begin
        stream_left = cur_arg;
        if (cur_arg == 8'h00) push_reply(KIND_SERIAL, cur_arg);
        else phase = STREAMING;
      end
      CMD_DUMMY_CLK: begin
        push_reply(KIND_DUMMY, cur_arg);
        push_reply(KIND_SERIAL, cur_arg);
      end
      CMD_END_PROG: begin
        sel_pin = 1'b1;
        rst_pin = 1'b1;
        push_reply(KIND_PINS, 8'h00);
        push_reply(KIND_SERIAL, REPLY_END);
      end
      CMD_DONE_POLL: push_reply(KIND_SERIAL, dn ? REPLY_DONE : REPLY_BUSY);
      CMD_XFER: begin
        push_reply(KIND_SPI, cur_arg);
        phase = XFER_WAIT;
      end
      CMD_SELECT: begin
        sel_pin = cur_arg[0];
        push_reply(KIND_PINS, 8'h00);
        push_reply(KIND_SERIAL, {7'd0, cur_arg[0]});
      end
      CMD_ECHO: push_reply(KIND_SERIAL, cur_arg);
      default: begin  // loopback
        ind_pin = 1'b0;
        sel_pin = 1'b1;
        push_reply(KIND_PINS, 8'h00);
        sel_pin = 1'b0;
        push_reply(KIND_PINS, 8'h00);
        push_reply(KIND_SPI, LOOP_PREFIX);
        phase = LOOP_FIRST;
      end
    endcase
  endtask

  task automatic predict_bridge_replies(input logic act, input logic [7:0] b,
                                        input logic err, input logic dn);
    int n0;
    n0 = pending_replies.size();
    if (act == SERIAL_WORD) begin
      case (phase)
        WAIT_CMD: begin
          cur_cmd   = b;
          status_ok = !err;
          phase     = WAIT_ARG;
        end
        WAIT_ARG: begin
          cur_arg = b;
          if (err) status_ok = 1'b0;
          if (!status_ok) begin
            phase = WAIT_CMD;
            push_reply(KIND_SERIAL, REPLY_ERROR);
            push_reply(KIND_SERIAL, cur_cmd);
          end else begin
            run_command(dn);
          end
        end
        STREAMING: begin
          // the byte goes out even when it arrived with an error
          push_reply(KIND_SPI, b);
          if (err) begin
            status_ok = 1'b0;
            push_reply(KIND_SERIAL, ~cur_arg);
            phase = WAIT_CMD;
          end else begin
            stream_left = stream_left - 8'd1;
            if (stream_left == 8'h00) begin
              push_reply(KIND_SERIAL, cur_arg);
              phase = WAIT_CMD;
            end
          end
        end
        default: ;  // SPI reply awaited: serial word dropped
      endcase
    end else begin
      case (phase)
        XFER_WAIT: begin
          push_reply(KIND_SERIAL, b);
          phase = WAIT_CMD;
        end
        LOOP_FIRST: begin
          push_reply(KIND_SPI, cur_arg);
          phase = LOOP_SECOND;
        end
        LOOP_SECOND: begin
          push_reply(KIND_SPI, LOOP_PATTERN);
          phase = LOOP_THIRD;
        end
        LOOP_THIRD: begin
          if (b != cur_arg) ind_pin = 1'b1;
          push_reply(KIND_PINS, 8'h00);
          push_reply(KIND_SERIAL, b);
          sel_pin = 1'b1;
          push_reply(KIND_PINS, 8'h00);
          phase = WAIT_CMD;
        end
        default: ;  // no transfer pending: reply ignored
      endcase
    end
    if (pending_replies.size() > n0)
      pending_replies[pending_replies.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_word(input logic a, input logic [7:0] v, input logic e,
                          input logic d);
    host_word_t w;
    w = '{act: a, value: v, err: e, done: d, hold: 1'b0};
    host_words.push_back(w);
    stim_count++;
  endtask

  // word the block is expected to ignore; not counted toward the target
  task automatic add_noise(input logic a);
    host_word_t w;
    w = '{act: a, value: rand_byte(), err: coin(), done: coin(), hold: 1'b0};
    host_words.push_back(w);
  endtask

  task automatic add_hold();
    host_word_t w;
    w = '{act: SERIAL_WORD, value: 8'h00, err: 1'b0, done: 1'b0, hold: 1'b1};
    host_words.push_back(w);
  endtask

  // one well-formed command with random content, sometimes broken by
  // receive errors, stray SPI replies or serial words during a transfer
  task automatic queue_random_command();
    logic [7:0] code;
    logic [7:0] arg;
    bit         e_cmd;
    bit         e_arg;
    bit         e_byte;
    case ($urandom_range(0, 9))
      0: code = CMD_CFG_RESET;
      1: code = CMD_STREAM;
      2: code = CMD_DUMMY_CLK;
      3: code = CMD_END_PROG;
      4: code = CMD_DONE_POLL;
      5: code = CMD_XFER;
      6: code = CMD_SELECT;
      7: code = CMD_ECHO;
      8: code = CMD_LOOPBACK;
      default: begin
        code = rand_byte();
        while (is_bridge_cmd(code)) code = rand_byte();
      end
    endcase
    arg = rand_byte();
    // streams are mostly short; now and then a longer one
    if (code == CMD_STREAM) begin
      if ($urandom_range(0, 15) != 0) arg = 8'($urandom_range(0, 4));
      else arg = 8'($urandom_range(5, 60));
    end
    e_cmd = ($urandom_range(0, 19) == 0);
    e_arg = ($urandom_range(0, 19) == 0);
    add_word(SERIAL_WORD, code, e_cmd, coin());
    if ($urandom_range(0, 9) == 0) add_noise(SPI_WORD);
    add_word(SERIAL_WORD, arg, e_arg, coin());
    if (e_cmd || e_arg) return;
    case (code)
      CMD_STREAM: begin
        for (int i = 0; i < arg; i++) begin
          if ($urandom_range(0, 11) == 0) add_noise(SPI_WORD);
          e_byte = ($urandom_range(0, 29) == 0);
          add_word(SERIAL_WORD, rand_byte(), e_byte, coin());
          if (e_byte) break;  // stream is over after an error
        end
      end
      CMD_XFER: begin
        if ($urandom_range(0, 3) == 0) add_noise(SERIAL_WORD);
        add_word(SPI_WORD, rand_byte(), coin(), coin());
      end
      CMD_LOOPBACK: begin
        for (int k = 0; k < 3; k++) begin
          if ($urandom_range(0, 5) == 0) add_noise(SERIAL_WORD);
          if (k == 2 && coin()) add_word(SPI_WORD, arg, coin(), coin());
          else add_word(SPI_WORD, rand_byte(), coin(), coin());
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Driver: bursts with random gaps, model updated on every accepted word
  // ---------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_words
    host_word_t w;
    logic       nxt_valid;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        words_accepted++;
        predict_bridge_replies(action, byte_value, rx_error, done_level);
      end
      if (!in_valid || in_ready) begin
        nxt_valid = 1'b0;
        // drain point: release only once nothing is owed
        while (host_words.size() > 0 && host_words[0].hold &&
               pending_replies.size() == 0)
          void'(host_words.pop_front());
        if (gap_left > 0) begin
          gap_left--;
        end else if (host_words.size() > 0 && !host_words[0].hold) begin
          w = host_words.pop_front();
          action     <= w.act;
          byte_value <= w.value;
          rx_error   <= w.err;
          done_level <= w.done;
          nxt_valid  = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            // mostly short bursts, sometimes a long run with no gaps
            if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(20, 60);
            else burst_left = $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        in_valid <= nxt_valid;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: rotating ready pattern, reloaded at random intervals
  // ---------------------------------------------------------------------
  logic [15:0] ready_pattern = 16'hffff;
  int          pattern_left  = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        // all-ones gives stretches without stalls; never all zeros
        if ($urandom_range(0, 3) == 0) ready_pattern = 16'hffff;
        else ready_pattern = 16'($urandom_range(0, 16'hffff)) | 16'h0001;
        pattern_left = $urandom_range(20, 200);
      end else begin
        pattern_left--;
      end
      out_ready     <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every accepted result word against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    reply_word_t got;
    reply_word_t want;
    if (!rst && out_valid && out_ready) begin
      got.res.kind            = kind;
      got.res.out_byte        = out_byte;
      got.res.select_level    = select_level;
      got.res.reset_level     = reset_level;
      got.res.indicator_level = indicator_level;
      got.last                = last;
      if (pending_replies.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result word: kind %0d byte %h sel %b rst %b ind %b last %b",
                   kind, out_byte, select_level, reset_level, indicator_level, last);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        results_checked++;
        if (got !== want) begin
          if (mismatches < 10)
            $display("result %0d mismatch: exp kind %0d byte %h sel %b rst %b ind %b last %b%s",
                     results_checked, want.res.kind, want.res.out_byte,
                     want.res.select_level, want.res.reset_level,
                     want.res.indicator_level, want.last,
                     $sformatf(" / got kind %0d byte %h sel %b rst %b ind %b last %b",
                               kind, out_byte, select_level, reset_level,
                               indicator_level, last));
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    // stray SPI reply at idle, with flags set that must be ignored
    add_word(SPI_WORD, 8'hff, 1'b1, 1'b1);
    // config reset with done high, done poll with done low, then end prog and select
    add_word(SERIAL_WORD, CMD_CFG_RESET, 1'b0, 1'b1);
    add_word(SERIAL_WORD, 8'h00, 1'b0, 1'b1);
    add_word(SERIAL_WORD, CMD_DONE_POLL, 1'b0, 1'b0);
    add_word(SERIAL_WORD, 8'hff, 1'b0, 1'b0);
    add_word(SERIAL_WORD, CMD_END_PROG, 1'b0, 1'b0);
    add_word(SERIAL_WORD, 8'h00, 1'b0, 1'b0);
    add_word(SERIAL_WORD, CMD_SELECT, 1'b0, 1'b0);
    add_word(SERIAL_WORD, 8'h01, 1'b0, 1'b0);
    // receive error on the command byte, then on the argument byte
    add_word(SERIAL_WORD, 8'hff, 1'b1, 1'b0);
    add_word(SERIAL_WORD, 8'h00, 1'b0, 1'b0);
    add_word(SERIAL_WORD, CMD_ECHO, 1'b0, 1'b0);
    add_word(SERIAL_WORD, 8'ha5, 1'b1, 1'b0);
    // one-byte stream whose byte arrives with an error
    add_word(SERIAL_WORD, CMD_STREAM, 1'b0, 1'b0);
    add_word(SERIAL_WORD, 8'h01, 1'b0, 1'b0);
    add_word(SERIAL_WORD, 8'hff, 1'b1, 1'b0);
    // single transfer with a serial word arriving while the reply is awaited
    add_word(SERIAL_WORD, CMD_XFER, 1'b0, 1'b0);
    add_word(SERIAL_WORD, 8'h00, 1'b0, 1'b0);
    add_word(SERIAL_WORD, 8'h42, 1'b0, 1'b1);
    add_word(SPI_WORD, 8'hff, 1'b0, 1'b0);
    // loopback whose final reply mismatches, setting the indicator
    add_word(SERIAL_WORD, CMD_LOOPBACK, 1'b0, 1'b0);
    add_word(SERIAL_WORD, 8'h5a, 1'b0, 1'b0);
    add_word(SPI_WORD, 8'h00, 1'b0, 1'b0);
    add_word(SPI_WORD, 8'hff, 1'b0, 1'b0);
    add_word(SPI_WORD, 8'h33, 1'b0, 1'b0);
    add_hold();

    while (stim_count < TARGET_WORDS) begin
      queue_random_command();
      if (stim_count % HOLD_EVERY < 4) add_hold();
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (host_words.size() > 0 || in_valid || pending_replies.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d input words and %0d dispatched commands,",
             words_accepted, cmds_dispatched);
    $display("with %0d result words checked and %0d mismatches.",
             results_checked, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d words unsent and %0d results outstanding.",
             host_words.size(), pending_replies.size());
    $display("FAILURE");
    $finish;
  end

endmodule
